// ===== hdl/rpes_pkg.sv =====
// ----------------------------------------------------------------------------
// rpes_pkg - shared types for the row positive-element sorter
// Word formats, cell control bundle and sizing constants.
// ----------------------------------------------------------------------------
package rpes_pkg;

    localparam int MAX_COLS = 64;
    localparam int IDX_W    = $clog2(MAX_COLS);
    localparam int CNT_W    = $clog2(MAX_COLS + 1);

    typedef struct packed {
        logic [31:0] element_bits;
        logic        last_in_row;
        logic        last_row;
    } t_in_word;

    typedef struct packed {
        logic [31:0] sorted_bits;
        logic        row_done;
        logic        matrix_done;
    } t_out_word;

    // Broadcast from the sequencer to every cell
    typedef struct packed {
        logic             load;    // store word at slot len
        logic             insert;  // insert word into sorted chain
        logic             emit;    // shift row chain down one slot
        logic             pop;     // shift sorted chain down one slot
        logic [31:0]      word;
        logic             pos;
        logic [CNT_W-1:0] len;
        logic [CNT_W-1:0] npos;
    } t_cell_ctrl;

endpackage

// ===== hdl/row_positive_element_sorter.sv =====
// ----------------------------------------------------------------------------
// row_positive_element_sorter - sorts the positive elements of each row
// Loads a row, then emits it with positives ascending in positive slots.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | i_in_valid, i_in_word, o_in_stall | words in
//  out     | o_out_valid, o_out_word, i_out_stall | words out
//  cfg     | i_cfg_we, i_cfg_wdata            | mode write
//
//  A row is loaded word by word, then emitted word by word; the shared chain
//  of 64 cells holds one row at a time. Load and emit do not overlap, except
//  that the first word of a new row may enter while the final output word
//  waits.
//  Synchronous active-low reset empties the row; the row store needs none.
//  Output stall freezes the chain while it emits; input is stalled during emission.
// ----------------------------------------------------------------------------
module row_positive_element_sorter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  rpes_pkg::t_in_word  i_in_word,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output rpes_pkg::t_out_word o_out_word,
    input  logic                i_out_stall,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata
);

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    localparam int N = rpes_pkg::MAX_COLS;
    localparam int CW = rpes_pkg::CNT_W;

    logic          r_state, n_state;
    logic [CW-1:0] r_len,   n_len;     // elements loaded / left to emit
    logic [CW-1:0] r_npos,  n_npos;    // positives held in sorted chain
    logic          r_final, n_final;
    logic          r_is_float;         // mode: both formats order alike
    logic          r_ovalid, n_ovalid;
    rpes_pkg::t_out_word r_oword, n_oword;

    rpes_pkg::t_cell_ctrl w_ctrl;
    logic          w_acc;
    logic          w_pos;
    logic          w_step;             // one word leaves the chain
    logic          w_end;

    logic [N-1:0]  w_gt;
    logic [31:0]   w_sort [N];
    logic [31:0]   w_row  [N];
    logic [N-1:0]  w_posf;

    assign o_in_stall  = (r_state != ST_LOAD);
    assign w_acc       = i_in_valid && !o_in_stall;
    assign w_pos       = !i_in_word.element_bits[31] && (i_in_word.element_bits != 32'd0);
    assign w_end       = i_in_word.last_in_row || (r_len == CW'(N - 1));
    assign w_step      = (r_state == ST_EMIT) && (!r_ovalid || !i_out_stall);

    assign w_ctrl.load   = w_acc;
    assign w_ctrl.insert = w_acc && w_pos;
    assign w_ctrl.emit   = w_step;
    assign w_ctrl.pop    = w_step && w_posf[0];
    assign w_ctrl.word   = i_in_word.element_bits;
    assign w_ctrl.pos    = w_pos;
    assign w_ctrl.len    = r_len;
    assign w_ctrl.npos   = r_npos;

    // chain of cells; slot 0 is the head
    for (genvar g = 0; g < N; g++) begin : g_cell
        rpes_cell u_cell (
            .i_clk       (i_clk),
            .i_idx       (rpes_pkg::IDX_W'(g)),
            .i_ctrl      (w_ctrl),
            .i_gt_prev   ((g == 0) ? 1'b0  : w_gt[(g == 0) ? 0 : g - 1]),
            .i_sort_prev ((g == 0) ? 32'd0 : w_sort[(g == 0) ? 0 : g - 1]),
            .i_sort_next ((g == N - 1) ? 32'd0 : w_sort[(g == N - 1) ? g : g + 1]),
            .i_row_next  ((g == N - 1) ? 32'd0 : w_row[(g == N - 1) ? g : g + 1]),
            .i_pos_next  ((g == N - 1) ? 1'b0  : w_posf[(g == N - 1) ? g : g + 1]),
            .o_gt        (w_gt[g]),
            .o_sort      (w_sort[g]),
            .o_row       (w_row[g]),
            .o_pos       (w_posf[g])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_npos   = r_npos;
        n_final  = r_final;
        n_ovalid = r_ovalid && i_out_stall;
        n_oword  = r_oword;
        case (r_state)
            ST_LOAD: begin
                if (w_acc) begin
                    n_len   = r_len + CW'(1);
                    n_npos  = r_npos + CW'(w_pos);
                    n_final = r_final | i_in_word.last_row;
                    if (w_end) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (w_step) begin
                    n_ovalid             = 1'b1;
                    n_oword.sorted_bits  = w_posf[0] ? w_sort[0] : w_row[0];
                    n_oword.row_done     = (r_len == CW'(1));
                    n_oword.matrix_done  = (r_len == CW'(1)) && r_final;
                    n_len                = r_len - CW'(1);
                    n_npos               = r_npos - CW'(w_posf[0]);
                    if (r_len == CW'(1)) begin
                        n_state = ST_LOAD;
                        n_final = 1'b0;
                        n_npos  = '0;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_len      <= '0;
            r_npos     <= '0;
            r_final    <= 1'b0;
            r_ovalid   <= 1'b0;
            r_is_float <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_npos   <= n_npos;
            r_final  <= n_final;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_is_float <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_oword <= n_oword;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;

endmodule

// ===== hdl/rpes_cell.sv =====
// ----------------------------------------------------------------------------
// rpes_cell - one slot of the sorter chain
// Holds one row element, its positive flag and one sorted positive value.
// ----------------------------------------------------------------------------
module rpes_cell (
    input  logic                       i_clk,
    input  logic [rpes_pkg::IDX_W-1:0] i_idx,
    input  rpes_pkg::t_cell_ctrl       i_ctrl,
    input  logic                       i_gt_prev,
    input  logic [31:0]                i_sort_prev,
    input  logic [31:0]                i_sort_next,
    input  logic [31:0]                i_row_next,
    input  logic                       i_pos_next,
    output logic                       o_gt,
    output logic [31:0]                o_sort,
    output logic [31:0]                o_row,
    output logic                       o_pos
);

    logic [31:0] r_sort;
    logic [31:0] r_row;
    logic        r_pos;
    logic        w_occ;
    logic        w_here;

    assign w_occ  = {1'b0, i_idx} < i_ctrl.npos;
    assign w_here = {1'b0, i_idx} == i_ctrl.npos;
    assign o_gt   = w_occ && (r_sort > i_ctrl.word);
    assign o_sort = r_sort;
    assign o_row  = r_row;
    assign o_pos  = r_pos;

    // sorted chain: parallel insertion, or shift down on pop
    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert) begin
            if (i_gt_prev) begin
                r_sort <= i_sort_prev;
            end else if (o_gt || w_here) begin
                r_sort <= i_ctrl.word;
            end
        end else if (i_ctrl.pop) begin
            r_sort <= i_sort_next;
        end
    end

    // row chain: written in place, shifted out towards slot 0
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load && ({1'b0, i_idx} == i_ctrl.len)) begin
            r_row <= i_ctrl.word;
            r_pos <= i_ctrl.pos;
        end else if (i_ctrl.emit) begin
            r_row <= i_row_next;
            r_pos <= i_pos_next;
        end
    end

endmodule

// ===== hdl/rpes_checker.sv =====
// ----------------------------------------------------------------------------
// rpes_checker - port-level checks for the row sorter
// Watches the top-level ports only; bound to the top level.
// ----------------------------------------------------------------------------
module rpes_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input rpes_pkg::t_in_word  i_in_word,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input rpes_pkg::t_out_word o_out_word,
    input logic                i_out_stall
);

    a_matrix_on_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.matrix_done |-> o_out_word.row_done)
        else $error("matrix_done without row_done");

    a_end_starts_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_word.last_in_row |=> o_in_stall)
        else $error("input not stalled after row end");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

endmodule

bind row_positive_element_sorter rpes_checker u_rpes_checker (.*);
